[src/rv32ex_pkg.sv]
// ----------------------------------------------------------------------------
// rv32ex_pkg
// Shared types and codes for the RV32I execute unit.
// ----------------------------------------------------------------------------
package rv32ex_pkg;

  // Instruction categories as delivered by the decoder.
  localparam logic [3:0] OP_LOAD    = 4'd0;
  localparam logic [3:0] OP_FENCE   = 4'd1;
  localparam logic [3:0] OP_ALU_IMM = 4'd2;
  localparam logic [3:0] OP_AUIPC   = 4'd3;
  localparam logic [3:0] OP_STORE   = 4'd4;
  localparam logic [3:0] OP_ALU     = 4'd5;
  localparam logic [3:0] OP_LUI     = 4'd6;
  localparam logic [3:0] OP_BRANCH  = 4'd7;
  localparam logic [3:0] OP_JAL     = 4'd8;
  localparam logic [3:0] OP_JALR    = 4'd9;
  localparam logic [3:0] OP_SYSTEM  = 4'd10;

  // ALU func3 codes.
  localparam logic [2:0] F3_ADD  = 3'd0;
  localparam logic [2:0] F3_SLL  = 3'd1;
  localparam logic [2:0] F3_SLT  = 3'd2;
  localparam logic [2:0] F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR  = 3'd4;
  localparam logic [2:0] F3_SR   = 3'd5;
  localparam logic [2:0] F3_OR   = 3'd6;
  localparam logic [2:0] F3_AND  = 3'd7;

  // Branch func3 codes.
  localparam logic [2:0] F3_BEQ  = 3'd0;
  localparam logic [2:0] F3_BNE  = 3'd1;
  localparam logic [2:0] F3_BLT  = 3'd4;
  localparam logic [2:0] F3_BGE  = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6;
  localparam logic [2:0] F3_BGEU = 3'd7;

  // Load and store func3 codes.
  localparam logic [2:0] F3_LB  = 3'd0;
  localparam logic [2:0] F3_LH  = 3'd1;
  localparam logic [2:0] F3_LW  = 3'd2;
  localparam logic [2:0] F3_LBU = 3'd4;
  localparam logic [2:0] F3_LHU = 3'd5;
  localparam logic [2:0] F3_SW  = 3'd2;
  // Store func3 011 would be a doubleword store, which RV32I does not have.
  localparam logic [2:0] F3_SD_RESV = 3'd3;

  // Access sizes.
  localparam logic [1:0] SIZE_NONE = 2'd0;
  localparam logic [1:0] SIZE_BYTE = 2'd1;
  localparam logic [1:0] SIZE_HALF = 2'd2;
  localparam logic [1:0] SIZE_WORD = 2'd3;

  localparam int unsigned IN_BITS   = 135;
  localparam int unsigned IN_BYTES  = 17;
  localparam int unsigned OUT_BITS  = 100;
  localparam int unsigned OUT_BYTES = 13;

  // Declared from the top bit down, so op sits in the lowest bits.
  typedef struct packed {
    logic [31:0] src2;
    logic [31:0] src1;
    logic [29:0] pc_word;
    logic [31:0] imm;
    logic        func7_alt;
    logic        func7_zero;
    logic [2:0]  func3;
    logic [3:0]  op;
  } ex_in_t;

  // Declared from the top bit down, so rd_write sits in bit 0.
  typedef struct packed {
    logic [29:0] mem_word_address;
    logic        zero_extend;
    logic [1:0]  access_size;
    logic        mem_write;
    logic        is_load;
    logic        invalid;
    logic [29:0] next_pc;
    logic        npc_valid;
    logic [31:0] result;
    logic        rd_write;
  } ex_out_t;

  typedef struct packed {
    logic [31:0] result;
    logic        bad;
  } alu_res_t;

endpackage

[src/rv32ex_alu.sv]
// ----------------------------------------------------------------------------
// rv32ex_alu
// Register result path: ALU, immediate, auipc and link values.
// ----------------------------------------------------------------------------
module rv32ex_alu
  import rv32ex_pkg::*;
(
  input  ex_in_t   din,
  output alu_res_t res
);

  logic [31:0] a;
  logic [31:0] b;
  logic [4:0]  sh;
  logic [31:0] calc;
  logic        bad;
  logic [29:0] pc_inc;

  assign a      = din.src1;
  assign b      = (din.op == OP_ALU) ? din.src2 : din.imm;
  assign sh     = b[4:0];
  assign pc_inc = din.pc_word + 30'd1;

  always_comb begin
    calc = '0;
    bad  = 1'b0;
    case (din.op)
      OP_ALU_IMM, OP_ALU: begin
        if (din.op == OP_ALU && !din.func7_zero) begin
          // Only sub and sra use the alternate func7 on register ops.
          if (din.func7_alt && din.func3 == F3_ADD) begin
            calc = a - b;
          end else if (din.func7_alt && din.func3 == F3_SR) begin
            calc = 32'($signed(a) >>> sh);
          end else begin
            bad = 1'b1;
          end
        end else begin
          case (din.func3)
            F3_ADD:  calc = a + b;
            F3_SLL: begin
              if (din.func7_zero) calc = a << sh;
              else bad = 1'b1;
            end
            F3_SLT:  calc = {31'd0, $signed(a) < $signed(b)};
            F3_SLTU: calc = {31'd0, a < b};
            F3_XOR:  calc = a ^ b;
            F3_SR: begin
              if (din.func7_zero) calc = a >> sh;
              else if (din.func7_alt) calc = 32'($signed(a) >>> sh);
              else bad = 1'b1;
            end
            F3_OR:   calc = a | b;
            default: calc = a & b;
          endcase
        end
      end
      OP_AUIPC:        calc = din.imm + {din.pc_word, 2'b00};
      OP_LUI:          calc = din.imm;
      OP_JAL, OP_JALR: calc = {pc_inc, 2'b00};
      default:         calc = '0;
    endcase
  end

  assign res.bad    = bad;
  assign res.result = bad ? 32'd0 : calc;

endmodule

[src/rv32ex_ctl.sv]
// ----------------------------------------------------------------------------
// rv32ex_ctl
// Branch, jump, memory access and legality decode; merges the ALU result.
// ----------------------------------------------------------------------------
module rv32ex_ctl
  import rv32ex_pkg::*;
(
  input  ex_in_t   din,
  input  alu_res_t alu,
  output ex_out_t  dout
);

  logic [31:0] eff_addr;
  logic [31:0] br_tgt;
  logic [29:0] pc_inc;
  logic        lt_s;
  logic        lt_u;
  logic        eq;
  logic        take;
  logic        inv;

  assign eff_addr = din.src1 + din.imm;
  assign br_tgt   = {din.pc_word, 2'b00} + din.imm;
  assign pc_inc   = din.pc_word + 30'd1;
  assign lt_s     = $signed(din.src1) < $signed(din.src2);
  assign lt_u     = din.src1 < din.src2;
  assign eq       = din.src1 == din.src2;

  always_comb begin
    dout             = '0;
    inv              = 1'b0;
    take             = 1'b0;
    dout.result      = alu.result;
    case (din.op)
      OP_LOAD: begin
        dout.is_load          = 1'b1;
        dout.mem_word_address = eff_addr[31:2];
        case (din.func3)
          F3_LB:   dout.access_size = SIZE_BYTE;
          F3_LH:   dout.access_size = SIZE_HALF;
          F3_LW:   dout.access_size = SIZE_WORD;
          F3_LBU: begin
            dout.access_size = SIZE_BYTE;
            dout.zero_extend = 1'b1;
          end
          F3_LHU: begin
            dout.access_size = SIZE_HALF;
            dout.zero_extend = 1'b1;
          end
          default: inv = 1'b1;
        endcase
      end
      OP_FENCE: ;
      OP_ALU_IMM, OP_ALU, OP_AUIPC, OP_LUI, OP_JAL: dout.rd_write = 1'b1;
      OP_STORE: begin
        if (din.func3[2]) begin
          inv = 1'b1;
        end else begin
          dout.mem_write        = 1'b1;
          dout.mem_word_address = eff_addr[31:2];
          if (din.func3 == F3_SD_RESV) inv = 1'b1;
          else dout.access_size = din.func3[1:0] + 2'd1;
        end
      end
      OP_BRANCH: begin
        dout.npc_valid = 1'b1;
        case (din.func3)
          F3_BEQ:  take = eq;
          F3_BNE:  take = !eq;
          F3_BLT:  take = lt_s;
          F3_BGE:  take = !lt_s;
          F3_BLTU: take = lt_u;
          F3_BGEU: take = !lt_u;
          default: inv = 1'b1;
        endcase
        if (take) begin
          dout.next_pc = br_tgt[31:2];
          if (br_tgt[1]) inv = 1'b1;
        end else begin
          dout.next_pc = pc_inc;
        end
      end
      OP_JALR: begin
        dout.rd_write  = 1'b1;
        dout.npc_valid = 1'b1;
        dout.next_pc   = eff_addr[31:2];
        inv            = eff_addr[1];
      end
      OP_SYSTEM: begin
        if (!(din.imm[11:1] == 11'd0 && din.func3 == 3'd0)) inv = 1'b1;
      end
      default: inv = 1'b1;
    endcase
    dout.invalid = inv | alu.bad;
  end

endmodule

[src/rv32i_execute_unit_top.sv]
// ----------------------------------------------------------------------------
// rv32i_execute_unit_top
// Execute stage of an RV32I core: one decoded instruction in, one result out.
// ----------------------------------------------------------------------------
// Usage:
//   Decoded instructions arrive on the s_* stream, one per beat, and each one
//   produces exactly one result beat on the m_* stream, in order.
//   A beat is taken on a rising edge where tvalid and tready are both high.
//   The block is a two-register pipeline: the input beat is captured in an
//   input register, the execute logic (ALU, branch compare, address adder
//   and legality decode) sits between it and the result register.
//   An input beat goes to the input register and then to the result register.
//   Throughput is one instruction per cycle, set by the single pass through
//   the execute logic; both registers advance together whenever the result
//   register is empty or being drained.
//   When the receiver holds m_tready low, the result register holds its beat,
//   the input register fills behind it, and s_tready then drops; no beat is
//   lost or repeated. Removing the stall resumes full rate at once.
//   A synchronous active-high rst empties both registers; s_tready is high
//   in the first cycle after reset. The block keeps no other state.
// ----------------------------------------------------------------------------
module rv32i_execute_unit_top
  import rv32ex_pkg::*;
(
  input  logic                     clk,
  input  logic                     rst,
  input  logic                     s_tvalid,
  output logic                     s_tready,
  // Fields from bit 0 up: op[3:0], func3[6:4], func7_zero[7], func7_alt[8],
  // imm[40:9], pc_word[70:41], src1[102:71], src2[134:103], zero pad[135].
  input  logic [IN_BYTES*8-1:0]    s_tdata,
  output logic                     m_tvalid,
  input  logic                     m_tready,
  // Fields from bit 0 up: rd_write[0], result[32:1], npc_valid[33],
  // next_pc[63:34], invalid[64], is_load[65], mem_write[66],
  // access_size[68:67], zero_extend[69], mem_word_address[99:70],
  // zero pad[103:100].
  output logic [OUT_BYTES*8-1:0]   m_tdata
);

  logic     in_valid;
  ex_in_t   in_reg;
  logic     out_valid;
  ex_out_t  out_reg;
  logic     out_load;
  logic     in_load;
  alu_res_t alu_res;
  ex_out_t  ex_out;

  // The result register can take a new beat when it is empty or draining;
  // the input register moves forward at the same moment.
  assign out_load = !out_valid || m_tready;
  assign s_tready = !in_valid || out_load;
  assign in_load  = s_tvalid && s_tready;

  always_ff @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (s_tready) begin
      in_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_load) begin
      in_reg <= ex_in_t'(s_tdata[IN_BITS-1:0]);
    end
  end

  rv32ex_alu u_alu (
    .din (in_reg),
    .res (alu_res)
  );

  rv32ex_ctl u_ctl (
    .din  (in_reg),
    .alu  (alu_res),
    .dout (ex_out)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load && in_valid) begin
      out_reg <= ex_out;
    end
  end

  assign m_tvalid = out_valid;
  assign m_tdata  = {{(OUT_BYTES*8-OUT_BITS){1'b0}}, out_reg};

  // A filled input register always moves into an empty result register.
  a_advance: assert property (@(posedge clk) disable iff (rst)
    in_valid && !out_valid |=> out_valid)
    else $error("input beat did not advance into empty result register");

  // A result never claims both a load and a store.
  a_ld_st: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !(out_reg.is_load && out_reg.mem_write))
    else $error("result marked as both load and store");

  // Without a memory access there is no address, size or extension.
  a_no_mem: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reg.is_load && !out_reg.mem_write |->
      out_reg.mem_word_address == 30'd0 && out_reg.access_size == SIZE_NONE &&
      !out_reg.zero_extend)
    else $error("memory fields set on a non-memory result");

  // next_pc is zero unless it is flagged valid.
  a_npc: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_reg.npc_valid |-> out_reg.next_pc == 30'd0)
    else $error("next_pc set without npc_valid");

endmodule

[test/rv32i_execute_unit_top_tb.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rv32i_execute_unit_top_tb
// Self-checking bench for the RV32I execute stage.
// ----------------------------------------------------------------------------
// A short table of hand-picked instructions runs first: every category, the
// field extremes and the illegal encodings. About sixteen hundred random
// instructions follow. For each accepted instruction beat, the typed answer
// or else a local model of the execute stage gives the expected result, which
// goes on a queue. Every result beat from the block is then compared, field
// by field, with the oldest queued result. Both stream sides stall at random.
// ----------------------------------------------------------------------------
module rv32i_execute_unit_top_tb;
  import rv32ex_pkg::*;

  // Category codes above OP_SYSTEM are unused by the decoder.
  localparam logic [3:0] OP_UNUSED     = 4'd15;
  localparam logic [2:0] F3_LOAD_RESV  = 3'd3;
  localparam logic [2:0] F3_BR_RESV    = 3'd2;
  localparam int         RANDOM_COUNT  = 1600;
  localparam int         CYCLE_LIMIT   = 200000;
  localparam int         DRAIN_CYCLES  = 10;
  // Neither side idles while the cycle count is inside this window.
  localparam int         QUIET_FROM    = 800;
  localparam int         QUIET_TO      = 1400;

  typedef struct {
    ex_in_t  insn;
    bit      known;     // expected result is typed into the table
    ex_out_t answer;
  } insn_row_t;

  logic clk = 1'b0;
  logic rst;
  logic s_tvalid;
  logic s_tready;
  logic [IN_BYTES*8-1:0] s_tdata;
  logic m_tvalid;
  logic m_tready;
  logic [OUT_BYTES*8-1:0] m_tdata;

  insn_row_t program_rows[$];
  ex_out_t   pending_results[$];
  int        next_row = 0;
  int        driven_row = 0;
  int        beats_in = 0;
  int        cycle_count = 0;
  int        failures = 0;

  rv32i_execute_unit_top dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  // Execute-stage model: computes the one result beat that an instruction
  // produces. Everything is done in 32-bit modular arithmetic.
  function automatic ex_out_t execute_insn(ex_in_t i);
    ex_out_t     o;
    logic [31:0] pc_byte;
    logic [31:0] link;
    logic [31:0] sum;
    logic [31:0] target;
    logic        less_s;
    logic        take;
    o       = '0;
    pc_byte = {i.pc_word, 2'b00};
    link    = {i.pc_word + 30'd1, 2'b00};
    sum     = i.src1 + i.imm;
    less_s  = $signed(i.src1) < $signed(i.src2);
    take    = 1'b0;
    case (i.op)
      OP_LOAD: begin
        o.is_load          = 1'b1;
        o.mem_word_address = sum[31:2];
        case (i.func3)
          F3_LB:   o.access_size = SIZE_BYTE;
          F3_LH:   o.access_size = SIZE_HALF;
          F3_LW:   o.access_size = SIZE_WORD;
          F3_LBU:  begin
            o.access_size = SIZE_BYTE;
            o.zero_extend = 1'b1;
          end
          F3_LHU:  begin
            o.access_size = SIZE_HALF;
            o.zero_extend = 1'b1;
          end
          default: o.invalid = 1'b1;
        endcase
      end
      OP_FENCE: ;
      OP_ALU_IMM: begin
        o.rd_write = 1'b1;
        case (i.func3)
          F3_ADD:  o.result = sum;
          F3_SLL:  begin
            if (i.func7_zero) o.result = i.src1 << i.imm[4:0];
            else o.invalid = 1'b1;
          end
          F3_SLT:  o.result = {31'd0, $signed(i.src1) < $signed(i.imm)};
          F3_SLTU: o.result = {31'd0, i.src1 < i.imm};
          F3_XOR:  o.result = i.src1 ^ i.imm;
          F3_SR:   begin
            if (i.func7_zero) o.result = i.src1 >> i.imm[4:0];
            else if (i.func7_alt) o.result = $signed(i.src1) >>> i.imm[4:0];
            else o.invalid = 1'b1;
          end
          F3_OR:   o.result = i.src1 | i.imm;
          default: o.result = i.src1 & i.imm;
        endcase
      end
      OP_AUIPC: begin
        o.rd_write = 1'b1;
        o.result   = i.imm + pc_byte;
      end
      OP_STORE: begin
        if (i.func3[2]) begin
          o.invalid = 1'b1;
        end else begin
          o.mem_write        = 1'b1;
          o.mem_word_address = sum[31:2];
          if (i.func3 == F3_SD_RESV) o.invalid = 1'b1;
          else o.access_size = i.func3[1:0] + 2'd1;
        end
      end
      OP_ALU: begin
        o.rd_write = 1'b1;
        if (i.func7_zero) begin
          case (i.func3)
            F3_ADD:  o.result = i.src1 + i.src2;
            F3_SLL:  o.result = i.src1 << i.src2[4:0];
            F3_SLT:  o.result = {31'd0, less_s};
            F3_SLTU: o.result = {31'd0, i.src1 < i.src2};
            F3_XOR:  o.result = i.src1 ^ i.src2;
            F3_SR:   o.result = i.src1 >> i.src2[4:0];
            F3_OR:   o.result = i.src1 | i.src2;
            default: o.result = i.src1 & i.src2;
          endcase
        end else if (i.func7_alt && i.func3 == F3_ADD) begin
          o.result = i.src1 - i.src2;
        end else if (i.func7_alt && i.func3 == F3_SR) begin
          o.result = $signed(i.src1) >>> i.src2[4:0];
        end else begin
          o.invalid = 1'b1;
        end
      end
      OP_LUI: begin
        o.rd_write = 1'b1;
        o.result   = i.imm;
      end
      OP_BRANCH: begin
        o.npc_valid = 1'b1;
        target      = pc_byte + i.imm;
        case (i.func3)
          F3_BEQ:  take = i.src1 == i.src2;
          F3_BNE:  take = i.src1 != i.src2;
          F3_BLT:  take = less_s;
          F3_BGE:  take = !less_s;
          F3_BLTU: take = i.src1 < i.src2;
          F3_BGEU: take = !(i.src1 < i.src2);
          default: o.invalid = 1'b1;
        endcase
        if (take) begin
          o.next_pc = target[31:2];
          if (target[1]) o.invalid = 1'b1;
        end else begin
          o.next_pc = i.pc_word + 30'd1;
        end
      end
      OP_JAL: begin
        o.rd_write = 1'b1;
        o.result   = link;
      end
      OP_JALR: begin
        target      = {sum[31:1], 1'b0};
        o.rd_write  = 1'b1;
        o.result    = link;
        o.npc_valid = 1'b1;
        o.next_pc   = target[31:2];
        o.invalid   = target[1];
      end
      OP_SYSTEM: begin
        if (!(i.imm[11:1] == 11'd0 && i.func3 == 3'd0)) o.invalid = 1'b1;
      end
      default: o.invalid = 1'b1;
    endcase
    if (o.invalid && (i.op == OP_ALU_IMM || i.op == OP_ALU)) o.result = '0;
    return o;
  endfunction

  function automatic ex_in_t make_insn(logic [3:0] op, logic [2:0] f3, logic f7z,
                                       logic f7a, logic [31:0] imm,
                                       logic [29:0] pc, logic [31:0] a,
                                       logic [31:0] b);
    ex_in_t i;
    i.op         = op;
    i.func3      = f3;
    i.func7_zero = f7z;
    i.func7_alt  = f7a;
    i.imm        = imm;
    i.pc_word    = pc;
    i.src1       = a;
    i.src2       = b;
    return i;
  endfunction

  task automatic add_checked(ex_in_t i);
    program_rows.push_back('{insn: i, known: 1'b0, answer: '0});
  endtask

  task automatic add_known(ex_in_t i, ex_out_t o);
    program_rows.push_back('{insn: i, known: 1'b1, answer: o});
  endtask

  // Operand values lean on the corners where compares and shifts go wrong.
  function automatic logic [31:0] pick_word();
    case ($urandom_range(7))
      0:       return 32'h0000_0000;
      1:       return 32'hFFFF_FFFF;
      2:       return 32'h8000_0000;
      3:       return 32'h7FFF_FFFF;
      4:       return 32'($urandom_range(64));
      default: return $urandom();
    endcase
  endfunction

  // Mostly well-formed instructions with random operands; a few percent are
  // unused categories, and the func7 flags are sometimes scrambled.
  function automatic ex_in_t random_insn();
    ex_in_t i;
    i.op         = 4'($urandom_range(10));
    i.func3      = 3'($urandom_range(7));
    i.func7_zero = 1'($urandom_range(1));
    i.func7_alt  = 1'($urandom_range(1));
    i.imm        = pick_word();
    i.pc_word    = 30'($urandom());
    i.src1       = pick_word();
    i.src2       = ($urandom_range(3) == 0) ? i.src1 : pick_word();
    if ($urandom_range(99) < 4) i.op = OP_SYSTEM + 4'($urandom_range(1, 5));
    case (i.op)
      OP_ALU, OP_ALU_IMM: begin
        if ($urandom_range(99) < 85) begin
          i.func7_alt  = (i.func3 == F3_SR || (i.op == OP_ALU && i.func3 == F3_ADD))
                         && $urandom_range(1);
          i.func7_zero = !i.func7_alt;
        end
      end
      OP_BRANCH: begin
        // Short word-aligned offsets most of the time, so taken branches
        // usually land on a legal target.
        if ($urandom_range(99) < 80) i.imm = {{19{i.imm[12]}}, i.imm[12:2], 2'b00};
      end
      OP_JALR: begin
        if ($urandom_range(1)) i.imm = {{20{i.imm[11]}}, i.imm[11:0]};
      end
      OP_SYSTEM: begin
        if ($urandom_range(1)) begin
          i.imm   = 32'($urandom_range(1));
          i.func3 = 3'd0;
        end
      end
      default: ;
    endcase
    return i;
  endfunction

  task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      $error("%s mismatch: expected 0x%08h, got 0x%08h", name, want, got);
      failures++;
    end
  endtask

  // Instruction side: a beat is loaded when the bus is free or the current
  // beat is being taken, and its expected result is queued once it is taken.
  always @(posedge clk) begin
    if (rst) begin
      s_tvalid <= 1'b0;
    end else begin
      if (s_tvalid && s_tready) begin
        if (program_rows[driven_row].known)
          pending_results.push_back(program_rows[driven_row].answer);
        else
          pending_results.push_back(execute_insn(program_rows[driven_row].insn));
        beats_in++;
      end
      if (!s_tvalid || s_tready) begin
        if (next_row < program_rows.size() &&
            !((cycle_count < QUIET_FROM || cycle_count > QUIET_TO) &&
              $urandom_range(99) < 6)) begin
          s_tvalid   <= 1'b1;
          s_tdata    <= {{(IN_BYTES*8-IN_BITS){1'b0}}, program_rows[next_row].insn};
          driven_row = next_row;
          next_row++;
        end else begin
          s_tvalid <= 1'b0;
        end
      end
    end
  end

  // Result side: random back-pressure and the field-by-field comparison.
  always @(posedge clk) begin
    ex_out_t got;
    ex_out_t want;
    if (rst) begin
      m_tready <= 1'b0;
    end else begin
      m_tready <= !((cycle_count < QUIET_FROM || cycle_count > QUIET_TO) &&
                    $urandom_range(99) < 6);
      if (m_tvalid && m_tready) begin
        got = ex_out_t'(m_tdata[OUT_BITS-1:0]);
        if (pending_results.size() == 0) begin
          $error("result beat arrived with no instruction outstanding");
          failures++;
        end else begin
          want = pending_results.pop_front();
          check_field("rd_write", 32'(want.rd_write), 32'(got.rd_write));
          check_field("result", want.result, got.result);
          check_field("npc_valid", 32'(want.npc_valid), 32'(got.npc_valid));
          check_field("next_pc", 32'(want.next_pc), 32'(got.next_pc));
          check_field("invalid", 32'(want.invalid), 32'(got.invalid));
          check_field("is_load", 32'(want.is_load), 32'(got.is_load));
          check_field("mem_write", 32'(want.mem_write), 32'(got.mem_write));
          check_field("access_size", 32'(want.access_size), 32'(got.access_size));
          check_field("zero_extend", 32'(want.zero_extend), 32'(got.zero_extend));
          check_field("mem_word_address", 32'(want.mem_word_address),
                      32'(got.mem_word_address));
        end
      end
    end
  end

  // Watchdog: ends a run that never finishes and reports it as failed.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("simulation failed");
      $finish;
    end
  end

  initial begin
    ex_out_t o;
    rst      = 1'b1;
    s_tvalid = 1'b0;
    s_tdata  = '0;
    m_tready = 1'b0;

    // Directed table. Rows with a typed answer are the ones whose result is
    // obvious; all others go through the model.
    o = '0; o.rd_write = 1'b1; o.result = 32'h8000_0000;
    add_known(make_insn(OP_LUI, 3'd0, 1'b0, 1'b0, 32'h8000_0000, '0, '0, '0), o);
    // The link value of the very last word wraps to address zero.
    o = '0; o.rd_write = 1'b1;
    add_known(make_insn(OP_JAL, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 30'h3FFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF), o);
    o = '0;
    add_known(make_insn(OP_SYSTEM, 3'd0, 1'b0, 1'b0, 32'h0, 30'h0, '0, '0), o);
    add_known(make_insn(OP_FENCE, 3'd7, 1'b1, 1'b1, 32'hFFFF_FFFF, 30'h3FFF_FFFF,
                        32'hFFFF_FFFF, 32'hFFFF_FFFF), o);
    o = '0; o.invalid = 1'b1;
    add_known(make_insn(OP_SYSTEM, 3'd0, 1'b0, 1'b0, 32'h0000_0800, 30'h0, '0, '0), o);
    add_known(make_insn(OP_UNUSED, 3'd0, 1'b1, 1'b0, 32'h1234_5678, 30'h1, 32'h10,
                        32'h20), o);
    add_known(make_insn(OP_STORE, 3'd4, 1'b0, 1'b0, 32'h0, 30'h0, 32'h100, 32'h1), o);
    // Bad func7: the register is still written, with zero.
    o = '0; o.invalid = 1'b1; o.rd_write = 1'b1;
    add_known(make_insn(OP_ALU, F3_ADD, 1'b0, 1'b0, '0, '0, 32'h5, 32'h7), o);
    add_known(make_insn(OP_ALU_IMM, F3_SLL, 1'b0, 1'b1, 32'h1, '0, 32'h5, '0), o);
    o = '0; o.rd_write = 1'b1; o.result = 32'hFFFF_FFFF;
    add_known(make_insn(OP_ALU_IMM, F3_SR, 1'b0, 1'b1, 32'd31, '0, 32'h8000_0000,
                        '0), o);
    add_checked(make_insn(OP_SYSTEM, 3'd0, 1'b0, 1'b0, 32'h1, '0, '0, '0));
    // Both func7 flags set: the all-zero func7 reading takes priority.
    add_checked(make_insn(OP_ALU, F3_ADD, 1'b1, 1'b1, '0, '0, 32'hFFFF_FFFF, 32'h1));
    add_checked(make_insn(OP_ALU, F3_ADD, 1'b0, 1'b1, '0, '0, 32'h0, 32'h1));
    add_checked(make_insn(OP_ALU, F3_SLT, 1'b1, 1'b0, '0, '0, 32'h8000_0000,
                          32'h7FFF_FFFF));
    add_checked(make_insn(OP_ALU, F3_SLTU, 1'b1, 1'b0, '0, '0, 32'h8000_0000,
                          32'h7FFF_FFFF));
    add_checked(make_insn(OP_ALU, F3_SR, 1'b0, 1'b1, '0, '0, 32'h8000_0001,
                          32'hFFFF_FFE4));
    add_checked(make_insn(OP_ALU_IMM, F3_SLTU, 1'b0, 1'b0, 32'hFFFF_FFFF, '0,
                          32'hFFFF_FFFE, '0));
    // Taken branch to a half-word target raises invalid.
    add_checked(make_insn(OP_BRANCH, F3_BEQ, 1'b0, 1'b0, 32'h2, 30'h10, 32'h9, 32'h9));
    add_checked(make_insn(OP_BRANCH, F3_BR_RESV, 1'b0, 1'b0, 32'h8, 30'h10, '0, '0));
    // Not-taken branch at the top word wraps the next pc to zero.
    add_checked(make_insn(OP_BRANCH, F3_BLTU, 1'b0, 1'b0, 32'hFFFF_FFFC,
                          30'h3FFF_FFFF, 32'hFFFF_FFFF, 32'h0));
    add_checked(make_insn(OP_JALR, 3'd5, 1'b0, 1'b0, 32'h3, 30'h20, 32'h1000, '0));
    add_checked(make_insn(OP_LOAD, F3_LOAD_RESV, 1'b0, 1'b0, 32'hFFFF_FFFC, '0,
                          32'h0, '0));
    add_checked(make_insn(OP_LOAD, F3_LHU, 1'b0, 1'b0, 32'h7FF, '0, 32'hFFFF_F000, '0));
    add_checked(make_insn(OP_STORE, F3_SD_RESV, 1'b0, 1'b0, 32'h4, '0, 32'h8000_0000,
                          32'h1));
    add_checked(make_insn(OP_AUIPC, 3'd0, 1'b0, 1'b0, 32'hFFFF_F000, 30'h3FFF_FFFF,
                          '0, '0));

    for (int n = 0; n < RANDOM_COUNT; n++) add_checked(random_insn());

    repeat (8) @(posedge clk);
    rst <= 1'b0;

    while (!(beats_in == program_rows.size() && pending_results.size() == 0))
      @(posedge clk);
    // Give a stray extra beat the chance to show up.
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (failures == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule

[filelist.f]
src/rv32ex_pkg.sv
src/rv32ex_alu.sv
src/rv32ex_ctl.sv
src/rv32i_execute_unit_top.sv
test/rv32i_execute_unit_top_tb.sv
